/* src/spq_pkg.sv */
package spq_pkg;

    localparam int CAPACITY_DEF       = 16;
    localparam int PRIORITY_WIDTH_DEF = 16;
    localparam int PAYLOAD_WIDTH_DEF  = 32;
    localparam int REQ_TYPE_W         = 2;
    localparam int STATUS_W           = 2;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_ENQ   = 2'd0,
        REQ_DEQ   = 2'd1,
        REQ_QUERY = 2'd2
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // shift command broadcast to every cell of the chain
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_op_t;

endpackage

/* src/spq_req_if.sv */
interface spq_req_if #(
    parameter int PRIO_W = spq_pkg::PRIORITY_WIDTH_DEF,
    parameter int DATA_W = spq_pkg::PAYLOAD_WIDTH_DEF
) ();
    logic                            valid;
    logic                            ready;
    logic [spq_pkg::REQ_TYPE_W-1:0]  req_type;
    logic [PRIO_W-1:0]               priority_req;
    logic [DATA_W-1:0]               payload;

    modport source (output valid, req_type, priority_req, payload, input ready);
    modport sink (input valid, req_type, priority_req, payload, output ready);
endinterface

/* src/spq_rsp_if.sv */
interface spq_rsp_if #(
    parameter int PRIO_W = spq_pkg::PRIORITY_WIDTH_DEF,
    parameter int DATA_W = spq_pkg::PAYLOAD_WIDTH_DEF,
    parameter int OCC_W  = $clog2(spq_pkg::CAPACITY_DEF + 1)
) ();
    logic                          valid;
    logic                          ready;
    logic [spq_pkg::STATUS_W-1:0]  status;
    logic [DATA_W-1:0]             out_payload;
    logic signed [PRIO_W:0]        min_priority;
    logic [OCC_W-1:0]              occupancy;

    modport source (output valid, status, out_payload, min_priority, occupancy, input ready);
    modport sink (input valid, status, out_payload, min_priority, occupancy, output ready);
endinterface

/* src/spq_cell.sv */
module spq_cell #(
    parameter int PRIO_W = spq_pkg::PRIORITY_WIDTH_DEF,
    parameter int DATA_W = spq_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic              clk,
    input  spq_pkg::cell_op_t op,
    input  logic              occupied,
    input  logic [PRIO_W-1:0] new_prio,
    input  logic [DATA_W-1:0] new_data,
    input  logic [PRIO_W-1:0] left_prio,
    input  logic [DATA_W-1:0] left_data,
    input  logic              left_gt,
    input  logic [PRIO_W-1:0] right_prio,
    input  logic [DATA_W-1:0] right_data,
    output logic [PRIO_W-1:0] prio,
    output logic [DATA_W-1:0] data,
    output logic              gt
);

    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // new entry goes in front of this cell (empty cells count as greater)
    assign gt = !occupied || (prio_reg > new_prio);

    always_comb
    begin
        prio_next = prio_reg;
        data_next = data_reg;
        if (op.enq)
        begin
            if (left_gt)
            begin
                prio_next = left_prio;
                data_next = left_data;
            end
            else if (gt)
            begin
                prio_next = new_prio;
                data_next = new_data;
            end
        end
        else if (op.deq)
        begin
            prio_next = right_prio;
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign prio = prio_reg;
    assign data = data_reg;

endmodule

/* src/spq_resp.sv */
module spq_resp #(
    parameter int PRIO_W = spq_pkg::PRIORITY_WIDTH_DEF,
    parameter int DATA_W = spq_pkg::PAYLOAD_WIDTH_DEF,
    parameter int OCC_W  = $clog2(spq_pkg::CAPACITY_DEF + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [spq_pkg::REQ_TYPE_W-1:0] req_type,
    input  logic [PRIO_W-1:0]             req_prio,
    input  logic                          full,
    input  logic                          empty,
    input  logic                          head_gt,
    input  logic [PRIO_W-1:0]             head_prio,
    input  logic [DATA_W-1:0]             head_data,
    input  logic [PRIO_W-1:0]             second_prio,
    input  logic [OCC_W-1:0]              count_next,
    output logic                          in_ready,
    spq_rsp_if.source                     rsp
);
    import spq_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [STATUS_W-1:0]    status_reg;
    logic [STATUS_W-1:0]    status_next;
    logic [DATA_W-1:0]      payload_reg;
    logic [DATA_W-1:0]      payload_next;
    logic signed [PRIO_W:0] minp_reg;
    logic signed [PRIO_W:0] minp_next;
    logic [OCC_W-1:0]       occ_reg;
    logic [PRIO_W-1:0]      new_head;

    assign in_ready = !valid_reg || rsp.ready;

    always_comb
    begin
        status_next  = ST_OK;
        payload_next = '0;
        new_head     = head_prio;
        case (req_type)
            REQ_ENQ:
            begin
                if (full)
                    status_next = ST_FULL;
                else if (head_gt)
                    new_head = req_prio;
            end
            REQ_DEQ:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    payload_next = head_data;
                    new_head     = second_prio;
                end
            end
            default:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                    payload_next = head_data;
            end
        endcase
        if (count_next == '0)
            minp_next = '1;
        else
            minp_next = {1'b0, new_head};
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (rsp.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            payload_reg <= payload_next;
            minp_reg    <= minp_next;
            occ_reg     <= count_next;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_payload  = payload_reg;
    assign rsp.min_priority = minp_reg;
    assign rsp.occupancy    = occ_reg;

endmodule

/* src/stable_min_priority_queue_top.sv */
// channel | dir | fields                                        | beat
// req     | in  | req_type, priority_req, payload               | valid & ready
// rsp     | out | status, out_payload, min_priority, occupancy  | valid & ready
//
// one request per cycle while req.ready is high; every cell compares against the
// incoming priority and shifts in the same cycle
// the result shows in the cycle after its request beat, held in an output register
// req.ready drops only while that register is full and rsp.ready is low
// rst_n clears the entry count and the output valid; cell contents are not reset
module stable_min_priority_queue_top #(
    parameter int CAPACITY       = spq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH  = spq_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic [OCC_W-1:0]         count_reg;
    logic [OCC_W-1:0]         count_next;
    logic                     in_ready;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     enq_ok;
    logic                     deq_ok;
    cell_op_t                 op;

    // per cell taps of the chain
    logic [PRIORITY_WIDTH-1:0] cell_prio [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0]  cell_data [CAPACITY];
    logic                      cell_gt   [CAPACITY];

    assign req.ready = in_ready;
    assign accept    = req.valid && in_ready;
    assign full      = (count_reg == OCC_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign enq_ok    = accept && (req.req_type == REQ_ENQ) && !full;
    assign deq_ok    = accept && (req.req_type == REQ_DEQ) && !empty;
    assign op.enq    = enq_ok;
    assign op.deq    = deq_ok;

    always_comb
    begin
        count_next = count_reg;
        if (enq_ok)
            count_next = count_reg + 1'b1;
        else if (deq_ok)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // sorted chain: head at cell 0, enqueue shifts right, dequeue shifts left
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [PRIORITY_WIDTH-1:0] l_prio;
        logic [PAYLOAD_WIDTH-1:0]  l_data;
        logic                      l_gt;
        logic [PRIORITY_WIDTH-1:0] r_prio;
        logic [PAYLOAD_WIDTH-1:0]  r_data;

        if (i == 0)
        begin : g_first
            assign l_prio = '0;
            assign l_data = '0;
            assign l_gt   = 1'b0;
        end
        else
        begin : g_mid
            assign l_prio = cell_prio[i-1];
            assign l_data = cell_data[i-1];
            assign l_gt   = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_prio = cell_prio[i];
            assign r_data = cell_data[i];
        end
        else
        begin : g_inner
            assign r_prio = cell_prio[i+1];
            assign r_data = cell_data[i+1];
        end

        spq_cell #(
            .PRIO_W (PRIORITY_WIDTH),
            .DATA_W (PAYLOAD_WIDTH)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .occupied   (OCC_W'(i) < count_reg),
            .new_prio   (req.priority_req),
            .new_data   (req.payload),
            .left_prio  (l_prio),
            .left_data  (l_data),
            .left_gt    (l_gt),
            .right_prio (r_prio),
            .right_data (r_data),
            .prio       (cell_prio[i]),
            .data       (cell_data[i]),
            .gt         (cell_gt[i])
        );
    end

    spq_resp #(
        .PRIO_W (PRIORITY_WIDTH),
        .DATA_W (PAYLOAD_WIDTH),
        .OCC_W  (OCC_W)
    ) u_resp (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_type    (req.req_type),
        .req_prio    (req.priority_req),
        .full        (full),
        .empty       (empty),
        .head_gt     (cell_gt[0]),
        .head_prio   (cell_prio[0]),
        .head_data   (cell_data[0]),
        .second_prio (cell_prio[1]),
        .count_next  (count_next),
        .in_ready    (in_ready),
        .rsp         (rsp)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OCC_W'(CAPACITY))
        else $error("entry count above capacity");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        enq_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("enqueue did not grow the queue");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= OCC_W'(2)) |-> (cell_prio[0] <= cell_prio[1]))
        else $error("head cells out of order");

    a_occ_report: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (rsp.occupancy == count_reg) && rsp.valid)
        else $error("reported occupancy differs from entry count");
`endif

endmodule

/* bench/tb_stable_min_priority_queue_top.sv */
module tb_stable_min_priority_queue_top;

    import spq_pkg::*;

    // block sizes, taken from the package defaults the uut is built with
    localparam int CAP = CAPACITY_DEF;
    localparam int PW  = PRIORITY_WIDTH_DEF;
    localparam int DW  = PAYLOAD_WIDTH_DEF;
    localparam int OW  = $clog2(CAP + 1);

    // request code 3 has no package name; the block treats it like a query
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [PW:0] MIN_PRIO_EMPTY = '1;

    localparam int RANDOM_ITEMS = 1500;
    // last stretch of the random part runs with no idling on either side
    localparam int QUIET_TAIL   = 200;
    // cycles with no beat on either channel before the run is declared hung
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        status_t                status;
        logic [DW-1:0]          out_payload;
        logic signed [PW:0]     min_priority;
        logic [OW-1:0]          occupancy;
    } result_t;

    // one row of the directed part; a typed result overrides the prediction
    typedef struct {
        logic [REQ_TYPE_W-1:0]  kind;
        logic [PW-1:0]          prio;
        logic [DW-1:0]          data;
        bit                     typed;
        result_t                result;
    } row_t;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_min_priority_queue_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // sorted copy of the queue contents, head at index 0
    logic [PW-1:0] sorted_prio [CAP];
    logic [DW-1:0] sorted_data [CAP];
    int            sorted_count;

    // results owed by the block, oldest first
    result_t awaited_results [$];

    // typed expectation that travels with the request currently driven
    bit      cur_typed;
    result_t cur_result;

    result_t cur_check;
    result_t cur_predict;

    row_t    directed_rows [$];

    bit quiet;
    int stall_left;
    int idle_cycles;
    int fail_count;
    int req_beats;
    int rsp_beats;
    int full_seen;
    int empty_seen;
    int peak_occ;

    always #5 clk = ~clk;

    // apply one request to the sorted copy and return the result it owes
    function automatic result_t serve_request(input logic [REQ_TYPE_W-1:0] kind,
                                              input logic [PW-1:0] prio,
                                              input logic [DW-1:0] data);
        result_t res;
        int      pos;
        res.status      = ST_OK;
        res.out_payload = '0;
        if (kind == REQ_ENQ)
        begin
            if (sorted_count >= CAP)
                res.status = ST_FULL;
            else
            begin
                // new entry goes behind every entry of equal or smaller priority value
                pos = 0;
                while (pos < sorted_count && sorted_prio[pos] <= prio)
                    pos++;
                for (int k = sorted_count; k > pos; k--)
                begin
                    sorted_prio[k] = sorted_prio[k-1];
                    sorted_data[k] = sorted_data[k-1];
                end
                sorted_prio[pos] = prio;
                sorted_data[pos] = data;
                sorted_count++;
            end
        end
        else if (sorted_count == 0)
            res.status = ST_EMPTY;
        else if (kind == REQ_DEQ)
        begin
            res.out_payload = sorted_data[0];
            for (int k = 1; k < sorted_count; k++)
            begin
                sorted_prio[k-1] = sorted_prio[k];
                sorted_data[k-1] = sorted_data[k];
            end
            sorted_count--;
        end
        else
            res.out_payload = sorted_data[0];   // query and the unused code
        res.min_priority = (sorted_count == 0) ? MIN_PRIO_EMPTY
                                               : $signed({1'b0, sorted_prio[0]});
        res.occupancy    = OW'(sorted_count);
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // result check first, then the prediction for a request beat on the same edge;
    // a result always trails its request beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_beats++;
                if (awaited_results.size() == 0)
                    note_failure($sformatf("result beat %0d with nothing awaited", rsp_beats));
                else
                begin
                    cur_check = awaited_results.pop_front();
                    if (cur_check.status == ST_FULL)
                        full_seen++;
                    if (cur_check.status == ST_EMPTY)
                        empty_seen++;
                    if (rsp_ch.status !== cur_check.status ||
                        rsp_ch.out_payload !== cur_check.out_payload ||
                        rsp_ch.min_priority !== cur_check.min_priority ||
                        rsp_ch.occupancy !== cur_check.occupancy)
                        note_failure($sformatf(
                            {"result beat %0d: expected st %0d pl %h min %0d occ %0d,",
                             " got st %0d pl %h min %0d occ %0d"},
                            rsp_beats, cur_check.status, cur_check.out_payload,
                            cur_check.min_priority, cur_check.occupancy,
                            rsp_ch.status, rsp_ch.out_payload,
                            rsp_ch.min_priority, rsp_ch.occupancy));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                req_beats++;
                cur_predict = serve_request(req_ch.req_type, req_ch.priority_req,
                                            req_ch.payload);
                awaited_results.push_back(cur_typed ? cur_result : cur_predict);
                if (sorted_count > peak_occ)
                    peak_occ = sorted_count;
            end
            // watchdog on cycles with no beat at all
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no beat for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, awaited_results.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // result side back-pressure: random bursts of stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // drive one request beat, with an optional idle burst ahead of it
    task automatic send_beat(input logic [REQ_TYPE_W-1:0] kind,
                             input logic [PW-1:0] prio,
                             input logic [DW-1:0] data,
                             input bit typed,
                             input result_t typed_result);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.priority_req <= prio;
        req_ch.payload      <= data;
        cur_typed           <= typed;
        cur_result          <= typed_result;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic add_row(input logic [REQ_TYPE_W-1:0] kind, input logic [PW-1:0] prio,
                           input logic [DW-1:0] data, input bit typed,
                           input result_t result);
        row_t r;
        r.kind   = kind;
        r.prio   = prio;
        r.data   = data;
        r.typed  = typed;
        r.result = result;
        directed_rows.push_back(r);
    endtask

    initial
    begin
        result_t none;
        result_t empty_res;
        logic [REQ_TYPE_W-1:0] kind;
        logic [PW-1:0]         prio;
        int  mode_left;
        bit  filling;
        int  pick;

        clk                 = 1'b0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_ENQ;
        req_ch.priority_req = '0;
        req_ch.payload      = '0;
        rsp_ch.ready        = 1'b0;
        cur_typed           = 1'b0;
        cur_result          = '0;
        quiet               = 1'b0;
        stall_left          = 0;
        idle_cycles         = 0;
        fail_count          = 0;
        req_beats           = 0;
        rsp_beats           = 0;
        full_seen           = 0;
        empty_seen          = 0;
        peak_occ            = 0;
        sorted_count        = 0;
        mode_left           = 0;
        filling             = 1'b1;
        none                = '0;
        empty_res           = '{ST_EMPTY, '0, MIN_PRIO_EMPTY, '0};

        // directed part: empty handling, extremes, ties, full, then drain a few
        add_row(REQ_DEQ,    16'h5555, 32'hDEADBEEF, 1'b1, empty_res);
        add_row(REQ_QUERY,  16'hAAAA, 32'h01234567, 1'b1, empty_res);
        add_row(REQ_UNUSED, 16'hFFFF, 32'hFFFFFFFF, 1'b1, empty_res);
        add_row(REQ_ENQ,    16'hFFFF, 32'hFFFFFFFF, 1'b1, '{ST_OK, '0, 17'sd65535, 5'd1});
        add_row(REQ_ENQ,    16'h0000, 32'h00000000, 1'b1, '{ST_OK, '0, 17'sd0, 5'd2});
        add_row(REQ_QUERY,  16'h5555, 32'hFFFFFFFF, 1'b1, '{ST_OK, '0, 17'sd0, 5'd2});
        // equal priorities must leave in arrival order
        add_row(REQ_ENQ,    16'h8000, 32'h00000001, 1'b0, none);
        add_row(REQ_ENQ,    16'h8000, 32'h00000002, 1'b0, none);
        add_row(REQ_ENQ,    16'h8000, 32'h00000003, 1'b0, none);
        add_row(REQ_ENQ,    16'h0000, 32'hAAAAAAAA, 1'b0, none);
        add_row(REQ_ENQ,    16'h0000, 32'h55555555, 1'b0, none);
        add_row(REQ_ENQ,    16'hFFFF, 32'h12345678, 1'b0, none);
        add_row(REQ_ENQ,    16'h8000, 32'h00000004, 1'b0, none);
        add_row(REQ_ENQ,    16'h0001, 32'h80000000, 1'b0, none);
        add_row(REQ_ENQ,    16'h7FFF, 32'h7FFFFFFF, 1'b0, none);
        add_row(REQ_ENQ,    16'h8000, 32'h00000005, 1'b0, none);
        add_row(REQ_ENQ,    16'hFFFE, 32'hFEDCBA98, 1'b0, none);
        add_row(REQ_ENQ,    16'h0000, 32'h00000001, 1'b0, none);
        add_row(REQ_ENQ,    16'h8001, 32'hC3C3C3C3, 1'b0, none);
        add_row(REQ_ENQ,    16'h0100, 32'h3C3C3C3C, 1'b0, none);
        // queue now full: the entry is dropped
        add_row(REQ_ENQ,    16'h0000, 32'h5A5A5A5A, 1'b1, '{ST_FULL, '0, 17'sd0, 5'd16});
        add_row(REQ_UNUSED, 16'h0000, 32'h00000000, 1'b0, none);
        add_row(REQ_DEQ,    16'hFFFF, 32'hFFFFFFFF, 1'b0, none);
        add_row(REQ_DEQ,    16'h0000, 32'h00000000, 1'b0, none);
        add_row(REQ_DEQ,    16'h1234, 32'h89ABCDEF, 1'b0, none);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].kind, directed_rows[i].prio, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].result);

        // random part: fill and drain phases picked at random so that both the full
        // and the empty boundary are reached again and again
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            if (mode_left == 0)
            begin
                filling   = 1'($urandom_range(0, 1));
                mode_left = $urandom_range(8, 40);
            end
            mode_left--;
            pick = $urandom_range(0, 99);
            if (filling)
                kind = (pick < 70) ? REQ_ENQ : (pick < 88) ? REQ_DEQ :
                       (pick < 97) ? REQ_QUERY : REQ_UNUSED;
            else
                kind = (pick < 20) ? REQ_ENQ : (pick < 85) ? REQ_DEQ :
                       (pick < 97) ? REQ_QUERY : REQ_UNUSED;
            // mostly a narrow range so that ties are common
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: prio = PW'($urandom_range(0, 7));
                5, 6:          prio = PW'($urandom_range(0, 65535));
                7:             prio = '0;
                8:             prio = '1;
                default:       prio = PW'($urandom_range(16'hFFF8, 16'hFFFF));
            endcase
            send_beat(kind, prio, $urandom, 1'b0, none);
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // drain outstanding results, then a few more cycles for stray beats
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("sent %0d requests (%0d directed), checked %0d results, peak occupancy %0d",
                 req_beats, directed_rows.size(), rsp_beats, peak_occ);
        $display("full rejections %0d, empty dequeue/query %0d, failures %0d",
                 full_seen, empty_seen, fail_count);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
